[hdl/awb_pkg.sv]
// ----------------------------------------------------------------------------
// awb_pkg
// Shared types, constants and helpers of the affine warp bilinear unit.
// ----------------------------------------------------------------------------
package awb_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Coordinates and limits are carried in 13 bits, enough for 4096.
    localparam int LIM_W    = 13;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = 41;
    localparam int FIX_W    = 42;
    localparam int IPART_W  = FIX_W - 16;
    localparam int WEIGHT_W = 12;
    localparam int PIX_W    = 24;
    localparam int NBANKS   = 4;

    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [11:0] WEIGHT_ONE = 12'd2048;

    typedef enum logic [2:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_SRC_W    = 3'd6,
        REG_SRC_H    = 3'd7
    } reg_idx_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Transaction after the coordinate mapping.
    typedef struct packed {
        logic                     cmd;
        logic [7:0]               x;
        logic [7:0]               y;
        logic [PIX_W-1:0]         rgb;
        logic signed [FIX_W-1:0]  fx;
        logic signed [FIX_W-1:0]  fy;
    } map_item_t;

    // Control that travels alongside the store read.
    typedef struct packed {
        logic                ok;
        logic                sx0;
        logic                sy0;
        logic [WEIGHT_W-1:0] wx0;
        logic [WEIGHT_W-1:0] wx1;
        logic [WEIGHT_W-1:0] wy0;
        logic [WEIGHT_W-1:0] wy1;
    } blend_ctl_t;

    // Address inside a parity bank: half row times half width plus half column.
    function automatic logic [2*LIM_W-1:0] bank_addr(input logic [LIM_W-1:0] row,
                                                     input logic [LIM_W-1:0] col,
                                                     input logic [LIM_W-1:0] half_w);
        logic [2*LIM_W-1:0] prod;
        prod = {{(LIM_W+1){1'b0}}, row[LIM_W-1:1]} * {{LIM_W{1'b0}}, half_w};
        return prod + {{(LIM_W+1){1'b0}}, col[LIM_W-1:1]};
    endfunction

endpackage

[hdl/awb_ram.sv]
// ----------------------------------------------------------------------------
// awb_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module awb_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/awb_map.sv]
// ----------------------------------------------------------------------------
// awb_map
// Two stage destination-to-source mapping: products, then sums.
// ----------------------------------------------------------------------------
module awb_map
    import awb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic                     cmd,
    input  logic [7:0]               x_coord,
    input  logic [7:0]               y_coord,
    input  logic [PIX_W-1:0]         rgb,
    input  logic signed [COEF_W-1:0] coef_xx,
    input  logic signed [COEF_W-1:0] coef_xy,
    input  logic signed [COEF_W-1:0] offset_x,
    input  logic signed [COEF_W-1:0] coef_yx,
    input  logic signed [COEF_W-1:0] coef_yy,
    input  logic signed [COEF_W-1:0] offset_y,
    output logic                     map_valid,
    output map_item_t                map_item
);

    logic                     v1_reg;
    logic                     cmd1_reg;
    logic [7:0]               x1_reg;
    logic [7:0]               y1_reg;
    logic [PIX_W-1:0]         rgb1_reg;
    logic signed [PROD_W-1:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg;
    logic signed [PROD_W-1:0] pxx_next, pxy_next, pyx_next, pyy_next;
    logic signed [COEF_W-1:0] offx1_reg, offy1_reg;
    logic                     v2_reg;
    map_item_t                item2_reg;
    map_item_t                item2_next;

    assign pxx_next = coef_xx * $signed({1'b0, x_coord});
    assign pxy_next = coef_xy * $signed({1'b0, y_coord});
    assign pyx_next = coef_yx * $signed({1'b0, x_coord});
    assign pyy_next = coef_yy * $signed({1'b0, y_coord});

    always_comb
    begin
        item2_next.cmd = cmd1_reg;
        item2_next.x   = x1_reg;
        item2_next.y   = y1_reg;
        item2_next.rgb = rgb1_reg;
        item2_next.fx  = FIX_W'(pxx_reg) + FIX_W'(pxy_reg) + FIX_W'(offx1_reg);
        item2_next.fy  = FIX_W'(pyx_reg) + FIX_W'(pyy_reg) + FIX_W'(offy1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg  <= cmd;
            x1_reg    <= x_coord;
            y1_reg    <= y_coord;
            rgb1_reg  <= rgb;
            pxx_reg   <= pxx_next;
            pxy_reg   <= pxy_next;
            pyx_reg   <= pyx_next;
            pyy_reg   <= pyy_next;
            offx1_reg <= offset_x;
            offy1_reg <= offset_y;
            item2_reg <= item2_next;
        end
    end

    assign map_valid = v2_reg;
    assign map_item  = item2_reg;

endmodule

[hdl/awb_blend.sv]
// ----------------------------------------------------------------------------
// awb_blend
// Bilinear blend of four neighbours: horizontal mix, then vertical mix.
// ----------------------------------------------------------------------------
module awb_blend
    import awb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             ctl_valid,
    input  blend_ctl_t       ctl,
    input  logic [PIX_W-1:0] p00,
    input  logic [PIX_W-1:0] p01,
    input  logic [PIX_W-1:0] p10,
    input  logic [PIX_W-1:0] p11,
    output logic             res_valid,
    output logic [PIX_W-1:0] res_rgb,
    output logic             res_inside
);

    logic                v4_reg;
    logic                ok4_reg;
    logic [WEIGHT_W-1:0] wy0_reg, wy1_reg;
    logic [19:0]         top_reg [3];
    logic [19:0]         bot_reg [3];
    logic [19:0]         top_next [3];
    logic [19:0]         bot_next [3];
    logic [7:0]          chan_next [3];
    logic [31:0]         acc [3];
    logic                vo_reg;
    logic [PIX_W-1:0]    rgb_reg;
    logic                inside_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            top_next[c] = 20'(p00[16-8*c +: 8] * ctl.wx0) + 20'(p10[16-8*c +: 8] * ctl.wx1);
            bot_next[c] = 20'(p01[16-8*c +: 8] * ctl.wx0) + 20'(p11[16-8*c +: 8] * ctl.wx1);
            acc[c] = 32'(top_reg[c] * wy0_reg) + 32'(bot_reg[c] * wy1_reg);
            chan_next[c] = ok4_reg ? acc[c][29:22] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= ctl_valid;
            vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok4_reg    <= ctl.ok;
            wy0_reg    <= ctl.wy0;
            wy1_reg    <= ctl.wy1;
            top_reg    <= top_next;
            bot_reg    <= bot_next;
            rgb_reg    <= {chan_next[0], chan_next[1], chan_next[2]};
            inside_reg <= ok4_reg;
        end
    end

    assign res_valid  = vo_reg;
    assign res_rgb    = rgb_reg;
    assign res_inside = inside_reg;

endmodule

[hdl/affine_warp_bilinear_unit.sv]
// ----------------------------------------------------------------------------
// affine_warp_bilinear_unit
// Inverse affine warp of a stored RGB image with bilinear interpolation.
// ----------------------------------------------------------------------------
// Usage: an input transaction with cmd load writes one source pixel into the
// pixel store; one with cmd sample maps the destination coordinate through
// the 2x3 Q16.16 matrix and returns one interpolated pixel on the output
// channel, with inside_res low and zero color when it falls off the image.
// Loads produce no output transaction.
// The store is split into four banks by row and column parity, so the four
// neighbours of a sample are read in the same cycle; loads and samples pass
// the store in order, so a sample sees every load accepted before it.
// Throughput is one transaction per cycle while out_stall does not hold the
// pipeline; a sample passes five register stages: two mapping stages, the
// store read, two blend stages. The whole pipeline advances only when the
// output register is empty or taken, so in_stall follows out_stall while a
// result waits.
// Reset clears the pipeline and sets identity matrix and 256x256 image size;
// the store contents are undefined until loaded. Configuration is written
// through cfg_write, cfg_index and cfg_data while the unit is idle.
// ----------------------------------------------------------------------------
module affine_warp_bilinear_unit
    import awb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  x_coord,
    input  logic [7:0]  y_coord,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        inside_res
);

    localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam logic [LIM_W-1:0] MAX_W_L  = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] MAX_H_L  = LIM_W'(MAX_HEIGHT);
    localparam logic [LIM_W-1:0] HALF_W_L = LIM_W'(HALF_W);

    logic signed [COEF_W-1:0] coef_xx_reg, coef_xy_reg, offset_x_reg;
    logic signed [COEF_W-1:0] coef_yx_reg, coef_yy_reg, offset_y_reg;
    logic [8:0]               src_w_reg, src_h_reg;

    logic       en;
    logic       map_valid;
    map_item_t  map_item;

    logic [LIM_W-1:0]   eff_w, eff_h;
    logic [IPART_W-1:0] ipx, ipy;
    logic               ok_x, ok_y;
    logic [16:0]        wx0_full, wy0_full;
    blend_ctl_t         ctl_next;
    blend_ctl_t         ctl_reg;
    logic               v3_reg;
    logic [LIM_W-1:0]   sx, sy, lx, ly;
    logic               load_ok;

    logic               bank_we    [NBANKS];
    logic [BANK_AW-1:0] bank_waddr [NBANKS];
    logic [BANK_AW-1:0] bank_raddr [NBANKS];
    logic [PIX_W-1:0]   bank_rdata [NBANKS];
    logic [LIM_W-1:0]   rcol [NBANKS];
    logic [LIM_W-1:0]   rrow [NBANKS];
    logic [LIM_W-1:0]   wcol, wrow;

    logic [PIX_W-1:0]   p00, p01, p10, p11;
    logic [PIX_W-1:0]   res_rgb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg  <= 32'sd65536;
            coef_xy_reg  <= '0;
            offset_x_reg <= '0;
            coef_yx_reg  <= '0;
            coef_yy_reg  <= 32'sd65536;
            offset_y_reg <= '0;
            src_w_reg    <= 9'd256;
            src_h_reg    <= 9'd256;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_COEF_XX:  coef_xx_reg  <= cfg_data;
                REG_COEF_XY:  coef_xy_reg  <= cfg_data;
                REG_OFFSET_X: offset_x_reg <= cfg_data;
                REG_COEF_YX:  coef_yx_reg  <= cfg_data;
                REG_COEF_YY:  coef_yy_reg  <= cfg_data;
                REG_OFFSET_Y: offset_y_reg <= cfg_data;
                REG_SRC_W:    src_w_reg    <= cfg_data[8:0];
                REG_SRC_H:    src_h_reg    <= cfg_data[8:0];
                default:      ;
            endcase
        end
    end

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    awb_map u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .rgb       ({in_red, in_green, in_blue}),
        .coef_xx   (coef_xx_reg),
        .coef_xy   (coef_xy_reg),
        .offset_x  (offset_x_reg),
        .coef_yx   (coef_yx_reg),
        .coef_yy   (coef_yy_reg),
        .offset_y  (offset_y_reg),
        .map_valid (map_valid),
        .map_item  (map_item)
    );

    // Split the mapped coordinate into neighbour position and weights.
    always_comb
    begin
        eff_w = ({4'd0, src_w_reg} > MAX_W_L) ? MAX_W_L : {4'd0, src_w_reg};
        eff_h = ({4'd0, src_h_reg} > MAX_H_L) ? MAX_H_L : {4'd0, src_h_reg};
        ipx   = map_item.fx[FIX_W-1:16];
        ipy   = map_item.fy[FIX_W-1:16];
        ok_x  = !map_item.fx[FIX_W-1] && (eff_w >= LIM_W'(2))
                && (ipx < IPART_W'(eff_w - LIM_W'(1)));
        ok_y  = !map_item.fy[FIX_W-1] && (eff_h >= LIM_W'(2))
                && (ipy < IPART_W'(eff_h - LIM_W'(1)));
        wx0_full = (ONE_Q16 - {1'b0, map_item.fx[15:0]}) >> 5;
        wy0_full = (ONE_Q16 - {1'b0, map_item.fy[15:0]}) >> 5;
        sx    = ipx[LIM_W-1:0];
        sy    = ipy[LIM_W-1:0];

        ctl_next.ok  = ok_x && ok_y;
        ctl_next.sx0 = sx[0];
        ctl_next.sy0 = sy[0];
        ctl_next.wx0 = wx0_full[WEIGHT_W-1:0];
        ctl_next.wx1 = WEIGHT_ONE - wx0_full[WEIGHT_W-1:0];
        ctl_next.wy0 = wy0_full[WEIGHT_W-1:0];
        ctl_next.wy1 = WEIGHT_ONE - wy0_full[WEIGHT_W-1:0];

        lx      = {5'd0, map_item.x};
        ly      = {5'd0, map_item.y};
        load_ok = (lx < MAX_W_L) && (ly < MAX_H_L);
        wcol    = lx;
        wrow    = ly;
    end

    // Bank b holds pixels with row parity b[1] and column parity b[0].
    for (genvar b = 0; b < NBANKS; b++)
    begin : g_bank
        always_comb
        begin
            rcol[b] = sx + LIM_W'(sx[0] != b[0]);
            rrow[b] = sy + LIM_W'(sy[0] != b[1]);
            bank_raddr[b] = BANK_AW'(bank_addr(rrow[b], rcol[b], HALF_W_L));
            bank_waddr[b] = BANK_AW'(bank_addr(wrow, wcol, HALF_W_L));
            bank_we[b]    = en && map_valid && (map_item.cmd == CMD_LOAD) && load_ok
                            && (wrow[0] == b[1]) && (wcol[0] == b[0]);
        end

        awb_ram
        #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH),
            .AW    (BANK_AW)
        )
        u_ram
        (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (bank_waddr[b]),
            .wdata (map_item.rgb),
            .re    (en),
            .raddr (bank_raddr[b]),
            .rdata (bank_rdata[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= map_valid && (map_item.cmd == CMD_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign p00 = bank_rdata[{ctl_reg.sy0, ctl_reg.sx0}];
    assign p10 = bank_rdata[{ctl_reg.sy0, !ctl_reg.sx0}];
    assign p01 = bank_rdata[{!ctl_reg.sy0, ctl_reg.sx0}];
    assign p11 = bank_rdata[{!ctl_reg.sy0, !ctl_reg.sx0}];

    awb_blend u_blend
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl_valid  (v3_reg),
        .ctl        (ctl_reg),
        .p00        (p00),
        .p01        (p01),
        .p10        (p10),
        .p11        (p11),
        .res_valid  (out_valid),
        .res_rgb    (res_rgb),
        .res_inside (inside_res)
    );

    assign out_red   = res_rgb[23:16];
    assign out_green = res_rgb[15:8];
    assign out_blue  = res_rgb[7:0];

endmodule
